// ===== sv/msa_pkg.sv =====
package msa_pkg;

    // Field widths fixed by the item formats.
    localparam int CMD_W     = 2;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int BIN_W     = 7;
    localparam int SAMPLE_W  = 32;
    localparam int SUM_W     = 64;
    localparam int AVG_W     = 32;
    localparam int SCAN_W    = 16;
    localparam int FRAME_W   = 12;
    localparam int FPS_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Default geometry of the store.
    localparam int ROWS_DEFAULT = 48;
    localparam int COLS_DEFAULT = 48;
    localparam int BINS_DEFAULT = 128;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SCANS  = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_SCAN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCANS_TO_AVERAGE = 1'd1;
    localparam logic [FPS_W-1:0]     FRAMES_PER_SCAN_RESET  = 13'd2304;
    localparam logic [SCAN_W-1:0]    SCANS_TO_AVERAGE_RESET = 16'd8;
    localparam logic [SCAN_W-1:0]    SCAN_MAX               = 16'hFFFF;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [BIN_W-1:0]    bin;
        logic [SAMPLE_W-1:0] sample;
        logic                frame_end;
    } item_t;

    typedef struct packed {
        logic [AVG_W-1:0]    average;
        logic [SCAN_W-1:0]   scans_done;
        logic                ready_res;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ===== sv/msa_divider.sv =====
module msa_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [msa_pkg::SUM_W-1:0]         dividend,
    input  logic [msa_pkg::SCAN_W-1:0]        divisor,
    output logic                              done,
    output logic [msa_pkg::SUM_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(msa_pkg::SUM_W);

    logic [msa_pkg::SUM_W-1:0]  quo_reg;
    logic [msa_pkg::SCAN_W-1:0] rem_reg;
    logic [msa_pkg::SCAN_W-1:0] rem_next;
    logic [msa_pkg::SCAN_W-1:0] div_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [msa_pkg::SCAN_W:0]   rem_shift;
    logic                       qbit;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[msa_pkg::SUM_W-1]};
        qbit      = (rem_shift >= {1'b0, div_reg});
        if (qbit)
        begin
            rem_next = msa_pkg::SCAN_W'(rem_shift - {1'b0, div_reg});
        end
        else
        begin
            rem_next = rem_shift[msa_pkg::SCAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(msa_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[msa_pkg::SUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/multi_scan_spectrum_averager_core.sv =====
// Multi-scan spectrum averager. One 64-bit sum is kept per (row, col, bin) in
// a single-port-read, single-port-write memory with a registered read port,
// and every item gives exactly one result. An accumulate goes through a
// memory read, an add and write back, and a result load; a read that finds
// completed scans waits on the 64-step bit-serial divider that divides the
// sum by the scan count; a dropped item, a read with no scans and the unused
// command go straight from acceptance to the result load. After reset and on
// every clear command the block sweeps all ROWS*COLS*BINS memory entries
// (294912 with the default geometry) one entry per cycle, and takes no item
// meanwhile; configuration writes are taken at any time. A finished result
// waits in an output register, so a new item is accepted while that result
// is not yet taken.
module multi_scan_spectrum_averager_core #(
    parameter int ROWS = msa_pkg::ROWS_DEFAULT,
    parameter int COLS = msa_pkg::COLS_DEFAULT,
    parameter int BINS = msa_pkg::BINS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  msa_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output msa_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [msa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [msa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH  = ROWS * COLS * BINS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [msa_pkg::ROW_W:0] ROW_LIMIT = (msa_pkg::ROW_W + 1)'(ROWS);
    localparam logic [msa_pkg::COL_W:0] COL_LIMIT = (msa_pkg::COL_W + 1)'(COLS);
    localparam logic [msa_pkg::BIN_W:0] BIN_LIMIT = (msa_pkg::BIN_W + 1)'(BINS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [ADDR_W-1:0]                clr_ptr_reg;
    logic                             clr_result_reg;
    logic [ADDR_W-1:0]                idx_reg;
    logic [msa_pkg::SAMPLE_W-1:0]     sample_reg;
    logic                             frame_end_reg;
    logic [msa_pkg::AVG_W-1:0]        avg_reg;
    logic [msa_pkg::STATUS_W-1:0]     status_reg;
    logic [msa_pkg::FRAME_W-1:0]      frame_reg;
    logic [msa_pkg::SCAN_W-1:0]       scan_reg;
    logic [msa_pkg::FPS_W-1:0]        fps_reg;
    logic [msa_pkg::SCAN_W-1:0]       sta_reg;
    logic                             result_valid_reg;
    msa_pkg::result_t                 result_reg;

    logic [msa_pkg::SUM_W-1:0]        sum_mem [DEPTH];
    logic [msa_pkg::SUM_W-1:0]        mem_rdata_reg;
    logic                             mem_re;
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [msa_pkg::SUM_W-1:0]        mem_wdata;

    logic                             accept;
    logic                             in_range;
    logic [ADDR_W-1:0]                item_idx;
    logic [msa_pkg::FPS_W-1:0]        frame_inc;
    logic                             slot_free;
    logic                             div_start;
    logic                             div_done;
    logic [msa_pkg::SUM_W-1:0]        div_quotient;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign in_range   = ({1'b0, item.row} < ROW_LIMIT) && ({1'b0, item.col} < COL_LIMIT)
                        && ({1'b0, item.bin} < BIN_LIMIT);
    assign item_idx   = ADDR_W'((32'(item.row) * COLS + 32'(item.col)) * BINS
                        + 32'(item.bin));
    assign mem_re     = accept && in_range
                        && ((item.command == msa_pkg::CMD_ACCUMULATE)
                            || (item.command == msa_pkg::CMD_READ));
    assign slot_free  = !result_valid_reg || result_ready;
    assign div_start  = (state_reg == S_RDWAIT);
    assign frame_inc  = {1'b0, frame_reg} + 1'b1;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata_reg + {{(msa_pkg::SUM_W - msa_pkg::SAMPLE_W){1'b0}}, sample_reg};
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_ACC)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= sum_mem[item_idx];
        end
    end

    msa_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mem_rdata_reg),
        .divisor  (scan_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_ptr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = clr_result_reg ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        msa_pkg::CMD_ACCUMULATE: state_next = in_range ? S_ACC : S_RESULT;
                        msa_pkg::CMD_READ:
                        begin
                            if (in_range && (scan_reg != '0))
                            begin
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                state_next = S_RESULT;
                            end
                        end
                        msa_pkg::CMD_CLEAR: state_next = S_CLEAR;
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_ACC:    state_next = S_RESULT;
            S_RDWAIT: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_ptr_reg      <= '0;
            clr_result_reg   <= 1'b0;
            frame_reg        <= '0;
            scan_reg         <= '0;
            fps_reg          <= msa_pkg::FRAMES_PER_SCAN_RESET;
            sta_reg          <= msa_pkg::SCANS_TO_AVERAGE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    msa_pkg::REG_FRAMES_PER_SCAN:
                        fps_reg <= cfg_data[msa_pkg::FPS_W-1:0];
                    msa_pkg::REG_SCANS_TO_AVERAGE:
                        sta_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_CLEAR)
            begin
                if (clr_ptr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_ptr_reg <= '0;
                end
                else
                begin
                    clr_ptr_reg <= clr_ptr_reg + 1'b1;
                end
            end

            if (accept && (item.command == msa_pkg::CMD_CLEAR))
            begin
                clr_ptr_reg    <= '0;
                clr_result_reg <= 1'b1;
                frame_reg      <= '0;
                scan_reg       <= '0;
            end

            // A frame closes on the write-back of an in-range accumulate.
            if ((state_reg == S_ACC) && frame_end_reg)
            begin
                if ((frame_inc >= fps_reg) || frame_inc[msa_pkg::FRAME_W])
                begin
                    frame_reg <= '0;
                    if (scan_reg != msa_pkg::SCAN_MAX)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                else
                begin
                    frame_reg <= frame_inc[msa_pkg::FRAME_W-1:0];
                end
            end

            if ((state_reg == S_RESULT) && slot_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg       <= item_idx;
            sample_reg    <= item.sample;
            frame_end_reg <= item.frame_end;
            avg_reg       <= '0;
            if (((item.command == msa_pkg::CMD_ACCUMULATE)
                 || (item.command == msa_pkg::CMD_READ)) && !in_range)
            begin
                status_reg <= msa_pkg::STATUS_DROPPED;
            end
            else if ((item.command == msa_pkg::CMD_READ) && (scan_reg == '0))
            begin
                status_reg <= msa_pkg::STATUS_NO_SCANS;
            end
            else
            begin
                status_reg <= msa_pkg::STATUS_OK;
            end
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            avg_reg <= div_quotient[msa_pkg::AVG_W-1:0];
        end
        if ((state_reg == S_RESULT) && slot_free)
        begin
            result_reg.average    <= avg_reg;
            result_reg.scans_done <= scan_reg;
            result_reg.ready_res  <= (scan_reg >= sta_reg);
            result_reg.status     <= status_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import msa_pkg::*;

    localparam int ROWS = ROWS_DEFAULT;
    localparam int COLS = COLS_DEFAULT;
    localparam int BINS = BINS_DEFAULT;
    localparam int unsigned FRAME_WRAP = 1 << FRAME_W;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int STEPS = 21;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int FRAME_BINS = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int FPS_PLAN [PHASES] = '{1, 2, 0, 5, 3, 4096};
    localparam int STA_PLAN [PHASES] = '{1, 0, 3, 65535, 12, 2};

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_DATA_W-1:0] fps_val;
        logic [CFG_DATA_W-1:0] sta_val;
        item_t                 it;
        bit                    typed;
        result_t               want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Expected behavior of the averager.
    logic [SUM_W-1:0] bin_sums [int unsigned];
    int unsigned frames_seen;
    int unsigned scans_seen;
    int unsigned fps_setting;
    int unsigned scans_wanted;
    result_t responses_due [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    bit idle_off = 1'b0;
    bit hold_off_req = 1'b0;
    step_t script [0:STEPS-1];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multi_scan_spectrum_averager_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic result_t averager_response(item_t it);
        result_t r;
        int unsigned idx;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] quot;
        bit hit;
        r = '0;
        hit = (it.row < ROWS) && (it.col < COLS) && (it.bin < BINS);
        idx = (int'(it.row) * COLS + int'(it.col)) * BINS + int'(it.bin);
        total = bin_sums.exists(idx) ? bin_sums[idx] : '0;
        case (it.command)
            CMD_ACCUMULATE:
                if (!hit)
                    r.status = STATUS_DROPPED;
                else
                begin
                    bin_sums[idx] = total + SUM_W'(it.sample);
                    if (it.frame_end)
                    begin
                        // A zero setting completes a scan on every frame, and the
                        // frame counter wraps at 4096 whatever the setting.
                        if (frames_seen + 1 >= fps_setting || frames_seen + 1 >= FRAME_WRAP)
                        begin
                            frames_seen = 0;
                            if (scans_seen < SCAN_MAX)
                                scans_seen++;
                        end
                        else
                            frames_seen++;
                    end
                end
            CMD_READ:
                if (!hit)
                    r.status = STATUS_DROPPED;
                else if (scans_seen == 0)
                    r.status = STATUS_NO_SCANS;
                else
                begin
                    quot = total / SUM_W'(scans_seen);
                    r.average = quot[AVG_W-1:0];
                end
            CMD_CLEAR:
            begin
                bin_sums.delete();
                frames_seen = 0;
                scans_seen = 0;
            end
            default: ;
        endcase
        r.scans_done = SCAN_W'(scans_seen);
        r.ready_res = (scans_seen >= scans_wanted);
        return r;
    endfunction

    function automatic step_t op(logic [CMD_W-1:0] cmd, int r, int c, int b,
                                 logic [SAMPLE_W-1:0] s, bit fe);
        step_t st;
        st = '0;
        st.it.command = cmd;
        st.it.row = ROW_W'(r);
        st.it.col = COL_W'(c);
        st.it.bin = BIN_W'(b);
        st.it.sample = s;
        st.it.frame_end = fe;
        return st;
    endfunction

    function automatic step_t op_known(step_t st, logic [AVG_W-1:0] avg, int scans,
                                       bit rdy, logic [STATUS_W-1:0] status);
        st.typed = 1'b1;
        st.want.average = avg;
        st.want.scans_done = SCAN_W'(scans);
        st.want.ready_res = rdy;
        st.want.status = status;
        return st;
    endfunction

    function automatic step_t config_row(logic [CFG_DATA_W-1:0] fps_val,
                                         logic [CFG_DATA_W-1:0] sta_val);
        step_t st;
        st = '0;
        st.is_cfg = 1'b1;
        st.fps_val = fps_val;
        st.sta_val = sta_val;
        return st;
    endfunction

    function automatic int near_edge(int limit);
        return $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(limit - 3, limit - 1);
    endfunction

    // Leaves item_valid high after the transfer; the caller's next action in the
    // same time step either presents the next item or lowers it.
    task automatic send_item(item_t it, bit typed, result_t want);
        int gap;
        result_t r;
        gap = idle_off ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        r = averager_response(it);
        responses_due.push_back(typed ? want : r);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] fps_val, logic [CFG_DATA_W-1:0] sta_val);
        item_valid <= 1'b0;
        while (responses_due.size() != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_FRAMES_PER_SCAN;
        cfg_data <= fps_val;
        @(posedge clk);
        cfg_index <= REG_SCANS_TO_AVERAGE;
        cfg_data <= sta_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        fps_setting = fps_val[FPS_W-1:0];
        scans_wanted = sta_val;
    endtask

    task automatic compare_response(result_t got);
        result_t want;
        if (responses_due.size() == 0)
        begin
            $display("%0t ns: result with no transfer outstanding: expected none, got %p",
                     $time, got);
            mismatch_count++;
            return;
        end
        want = responses_due.pop_front();
        if (got.average !== want.average)
        begin
            $display("%0t ns: average expected %0h, got %0h", $time, want.average, got.average);
            mismatch_count++;
        end
        if (got.scans_done !== want.scans_done)
        begin
            $display("%0t ns: scans_done expected %0d, got %0d",
                     $time, want.scans_done, got.scans_done);
            mismatch_count++;
        end
        if (got.ready_res !== want.ready_res)
        begin
            $display("%0t ns: ready_res expected %0b, got %0b",
                     $time, want.ready_res, got.ready_res);
            mismatch_count++;
        end
        if (got.status !== want.status)
        begin
            $display("%0t ns: status expected %0d, got %0d", $time, want.status, got.status);
            mismatch_count++;
        end
    endtask

    initial
    begin
        int stall;
        result_ready = 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                // Long hold so the output register fills and the input stalls.
                hold_off_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
                stall = idle_off ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            compare_response(result);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        item_t it;
        int pick;
        int cur_row;
        int cur_col;
        int frame_bin;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        frames_seen = 0;
        scans_seen = 0;
        fps_setting = FRAMES_PER_SCAN_RESET;
        scans_wanted = SCANS_TO_AVERAGE_RESET;

        script = '{
            op_known(op(CMD_READ, 0, 0, 0, 32'd0, 1'b0), 32'd0, 0, 1'b0, STATUS_NO_SCANS),
            op_known(op(CMD_READ, 48, 0, 0, 32'd0, 1'b0), 32'd0, 0, 1'b0, STATUS_DROPPED),
            op_known(op(CMD_ACCUMULATE, 63, 63, 127, 32'hFFFF_FFFF, 1'b1),
                     32'd0, 0, 1'b0, STATUS_DROPPED),
            op_known(op(CMD_ACCUMULATE, 0, 48, 5, 32'd123, 1'b1),
                     32'd0, 0, 1'b0, STATUS_DROPPED),
            op_known(op(CMD_UNUSED, 63, 63, 127, 32'hFFFF_FFFF, 1'b1),
                     32'd0, 0, 1'b0, STATUS_OK),
            config_row(16'hE000, 16'h0000),
            op_known(op(CMD_ACCUMULATE, 47, 47, 127, 32'hFFFF_FFFF, 1'b1),
                     32'd0, 1, 1'b1, STATUS_OK),
            op(CMD_ACCUMULATE, 47, 47, 127, 32'hFFFF_FFFF, 1'b0),
            op(CMD_READ, 47, 47, 127, 32'd0, 1'b0),
            op_known(op(CMD_READ, 0, 0, 0, 32'd0, 1'b0), 32'd0, 1, 1'b1, STATUS_OK),
            config_row(16'd3, 16'hFFFF),
            op(CMD_ACCUMULATE, 0, 0, 0, 32'd0, 1'b1),
            op(CMD_ACCUMULATE, 0, 0, 0, 32'h8000_0000, 1'b1),
            op(CMD_ACCUMULATE, 0, 0, 0, 32'd7, 1'b1),
            op(CMD_READ, 0, 0, 0, 32'd0, 1'b0),
            op(CMD_READ, 47, 47, 63, 32'd0, 1'b0),
            op_known(op(CMD_CLEAR, 63, 63, 127, 32'hFFFF_FFFF, 1'b1),
                     32'd0, 0, 1'b0, STATUS_OK),
            op_known(op(CMD_READ, 47, 47, 127, 32'd0, 1'b0), 32'd0, 0, 1'b0, STATUS_NO_SCANS),
            config_row(16'd1, 16'd1),
            op_known(op(CMD_ACCUMULATE, 5, 6, 7, 32'h1234_5678, 1'b1),
                     32'd0, 1, 1'b1, STATUS_OK),
            op(CMD_READ, 5, 6, 7, 32'd0, 1'b0)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
        begin
            if (script[k].is_cfg)
                set_config(script[k].fps_val, script[k].sta_val);
            else
                send_item(script[k].it, script[k].typed, script[k].want);
        end

        // Random part: frames of a few bins streamed into a small set of
        // positions, reads of those positions, and some noise.
        cur_row = near_edge(ROWS);
        cur_col = near_edge(COLS);
        frame_bin = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            set_config({3'($urandom), 13'(FPS_PLAN[p])}, 16'(STA_PLAN[p]));
            idle_off = (p == 2);
            if (p == 1)
                hold_off_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                it.sample = $urandom;
                it.row = ROW_W'($urandom);
                it.col = COL_W'($urandom);
                it.bin = BIN_W'($urandom);
                it.frame_end = 1'($urandom);
                if (pick < 8)
                begin
                    it.command = pick[0] ? CMD_READ : CMD_ACCUMULATE;
                    if (pick < 4)
                        it.row = ROW_W'($urandom_range(ROWS, 63));
                    else
                        it.col = COL_W'($urandom_range(COLS, 63));
                end
                else if (pick < 12)
                    it.command = CMD_UNUSED;
                else if (pick < 32)
                begin
                    it.command = CMD_READ;
                    if (pick >= 16)
                    begin
                        it.row = ROW_W'(near_edge(ROWS));
                        it.col = COL_W'(near_edge(COLS));
                        it.bin = BIN_W'($urandom_range(0, FRAME_BINS - 1));
                    end
                end
                else
                begin
                    it.command = CMD_ACCUMULATE;
                    it.row = ROW_W'(cur_row);
                    it.col = COL_W'(cur_col);
                    it.bin = BIN_W'(frame_bin);
                    it.frame_end = (frame_bin == FRAME_BINS - 1);
                    frame_bin = (frame_bin + 1) % FRAME_BINS;
                    if (frame_bin == 0)
                    begin
                        cur_row = near_edge(ROWS);
                        cur_col = near_edge(COLS);
                    end
                end
                send_item(it, 1'b0, '0);
            end
        end

        item_valid <= 1'b0;
        while (responses_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
